@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/psau_pkg.sv @@
// package with types and constants of the packet serial ack unwrapper
`timescale 1ns / 1ps
`default_nettype none
package psau_pkg;

   localparam int ID_SPACE_DEF = 16384;
   localparam int SERIAL_W     = 32;
   localparam int WIRE_W       = 16;
   localparam int PID_W        = 14;
   localparam int STATUS_W     = 3;

   localparam logic MODE_SEND = 1'b0;
   localparam logic MODE_ACK  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 3'd0,
      ST_BAD_WIRE       = 3'd1,
      ST_HALF_RANGE     = 3'd2,
      ST_BEFORE_SESSION = 3'd3,
      ST_FUTURE         = 3'd4
   } status_type;

   typedef struct packed {
      logic              mode;
      logic              has_bunches;
      logic [WIRE_W-1:0] wire_packet_id;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SERIAL_W-1:0] packet_serial;
      logic [PID_W-1:0]    packet_id;
      logic [SERIAL_W-1:0] highest_acked_serial;
   } rsp_type;

   // outcome of unwrapping one acked wire id
   typedef struct packed {
      status_type          status;
      logic [SERIAL_W-1:0] serial;
      logic                raise_ref;
      logic                raise_high;
   } ack_res_type;

endpackage
`default_nettype wire

@@ rtl/packet_serial_ack_unwrap.sv @@
// top level: packet serial allocator and ack wire id unwrapper
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_data  (mode, has_bunches, wire_packet_id)
//   rsp      out  rsp_valid/rsp_stall   rsp_data  (status, serial, id, highest acked)
//
// one transaction per cycle while req_stall is low; its result is registered and appears in the cycle after acceptance.
// the state update (modular distance, add, compare) completes in the accept cycle,
// so the next transaction sees it at once.
// reset clears the serial counter, unwrap reference and highest acked serial.
// req_stall is raised only while the result register is full and rsp_stall is high.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module packet_serial_ack_unwrap
   import psau_pkg::*;
#(
   parameter int ID_SPACE = ID_SPACE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int ID_W = $clog2(ID_SPACE);
   localparam logic [ID_W-1:0] ID_LAST = ID_W'(ID_SPACE - 1);

   logic [SERIAL_W-1:0] next_serial_ff, next_serial_in;
   logic [ID_W-1:0]     next_id_ff, next_id_in;
   logic [SERIAL_W-1:0] unwrap_ref_ff, unwrap_ref_in;
   logic [ID_W-1:0]     ref_id_ff, ref_id_in;
   logic [SERIAL_W-1:0] high_ack_ff, high_ack_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                accept;
   ack_res_type         ack_res;

   // ack unwrap against the current reference
   psau_ack_resolve #(
      .ID_SPACE (ID_SPACE)
   ) u_ack (
      .wire_id     (req_data.wire_packet_id),
      .ref_serial  (unwrap_ref_ff),
      .ref_id      (ref_id_ff),
      .next_serial (next_serial_ff),
      .high_serial (high_ack_ff),
      .res         (ack_res)
   );

   // handshake
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // state and result next values
   always_comb begin
      next_serial_in = next_serial_ff;
      next_id_in     = next_id_ff;
      unwrap_ref_in  = unwrap_ref_ff;
      ref_id_in      = ref_id_ff;
      high_ack_in    = high_ack_ff;
      rsp_data_in    = rsp_data_ff;
      if (accept) begin
         if (req_data.mode == MODE_SEND) begin
            next_serial_in = next_serial_ff + 1'b1;
            // counter wrap restarts the wire id too
            if (next_serial_ff == '1 || next_id_ff == ID_LAST) begin
               next_id_in = '0;
            end else begin
               next_id_in = next_id_ff + 1'b1;
            end
            if (!req_data.has_bunches && next_serial_ff > unwrap_ref_ff) begin
               unwrap_ref_in = next_serial_ff;
               ref_id_in     = next_id_ff;
            end
            rsp_data_in.status        = ST_OK;
            rsp_data_in.packet_serial = next_serial_ff;
            rsp_data_in.packet_id     = PID_W'(next_id_ff);
         end else begin
            // resolved serial is congruent to the wire id
            if (ack_res.raise_ref) begin
               unwrap_ref_in = ack_res.serial;
               ref_id_in     = req_data.wire_packet_id[ID_W-1:0];
            end
            if (ack_res.raise_high) begin
               high_ack_in = ack_res.serial;
            end
            rsp_data_in.status        = ack_res.status;
            rsp_data_in.packet_serial = ack_res.serial;
            rsp_data_in.packet_id     = '0;
         end
         rsp_data_in.highest_acked_serial = high_ack_in;
      end
   end

   // output register valid
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_serial_ff <= '0;
         next_id_ff     <= '0;
         unwrap_ref_ff  <= '0;
         ref_id_ff      <= '0;
         high_ack_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         next_serial_ff <= next_serial_in;
         next_id_ff     <= next_id_in;
         unwrap_ref_ff  <= unwrap_ref_in;
         ref_id_ff      <= ref_id_in;
         high_ack_ff    <= high_ack_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `ASSERT_CLK(a_next_id_range, clock, reset, next_id_ff <= ID_LAST && ref_id_ff <= ID_LAST, "wire id out of id space")
   `ASSERT_NEXT(a_ack_in_past, clock, reset, accept && req_data.mode == MODE_ACK && ack_res.status == ST_OK, rsp_data_ff.packet_serial < next_serial_ff, "resolved serial not yet sent")
   `ASSERT_NEXT(a_high_monotonic, clock, reset, 1'b1, high_ack_ff >= $past(high_ack_ff), "highest acked serial went down")

endmodule
`default_nettype wire

@@ rtl/psau_ack_resolve.sv @@
// unwraps an acked wire id against the reference serial
`timescale 1ns / 1ps
`default_nettype none
module psau_ack_resolve
   import psau_pkg::*;
#(
   parameter int ID_SPACE = ID_SPACE_DEF
) (
   input  wire logic [WIRE_W-1:0]            wire_id,
   input  wire logic [SERIAL_W-1:0]          ref_serial,
   input  wire logic [$clog2(ID_SPACE)-1:0]  ref_id,
   input  wire logic [SERIAL_W-1:0]          next_serial,
   input  wire logic [SERIAL_W-1:0]          high_serial,
   output ack_res_type                       res
);

   localparam int ID_W = $clog2(ID_SPACE);
   localparam int DW   = ID_W + 2;
   localparam int CW   = SERIAL_W + 2;
   localparam logic signed [DW-1:0] SPACE_S    = DW'(ID_SPACE);
   localparam logic signed [DW-1:0] HALF_S     = DW'(ID_SPACE / 2);
   localparam logic [WIRE_W:0]      SPACE_WIRE = (WIRE_W + 1)'(ID_SPACE);

   logic                 bad_wire;
   logic signed [DW-1:0] diff;
   logic signed [DW-1:0] fwd;
   logic signed [DW-1:0] delta;
   logic signed [CW-1:0] ref_s;
   logic signed [CW-1:0] next_s;
   logic signed [CW-1:0] high_s;
   logic signed [CW-1:0] cand;

   // forward distance modulo the id space, then folded to a signed step
   always_comb begin
      bad_wire = {1'b0, wire_id} >= SPACE_WIRE;
      diff     = $signed({2'b00, wire_id[ID_W-1:0]}) - $signed({2'b00, ref_id});
      fwd      = (diff < 0) ? diff + SPACE_S : diff;
      delta    = (fwd > HALF_S) ? fwd - SPACE_S : fwd;
      ref_s    = $signed({2'b00, ref_serial});
      next_s   = $signed({2'b00, next_serial});
      high_s   = $signed({2'b00, high_serial});
      cand     = ref_s + CW'(delta);
   end

   // status in priority order, state moves only on success
   always_comb begin
      res.serial     = '0;
      res.raise_ref  = 1'b0;
      res.raise_high = 1'b0;
      priority if (bad_wire) begin
         res.status = ST_BAD_WIRE;
      end else if (fwd == HALF_S) begin
         res.status = ST_HALF_RANGE;
      end else if (cand < 0) begin
         res.status = ST_BEFORE_SESSION;
      end else if (cand >= next_s) begin
         res.status = ST_FUTURE;
      end else begin
         res.status     = ST_OK;
         res.serial     = cand[SERIAL_W-1:0];
         res.raise_ref  = cand > ref_s;
         res.raise_high = cand > high_s;
      end
   end

endmodule
`default_nettype wire
